>>> design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared types, sizes and index helpers of the parity split deque
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

   localparam int unsigned DEPTH   = 16;
   localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned FILL_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_DEL_EVEN = 2'd1,
      OP_DEL_ODD  = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_NO_EVEN = 3'd2,
      ST_NO_ODD  = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the request beat
      logic exec;      // apply the operation to indices, count and store
      logic fetch;     // read front and back words
      logic load_rsp;  // place the result beat in the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;  // output register can take a beat this cycle
   } stat_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

endpackage

`default_nettype wire

>>> design/psd_ifs.sv
// ----------------------------------------------------------------------------
// psd_req_if / psd_rsp_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_req_if import psd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface psd_rsp_if import psd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [WORD_W-1:0] even_peek;
   logic signed [WORD_W-1:0] odd_peek;
   logic                     has_even;
   logic                     has_odd;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, output status, output even_peek, output odd_peek,
                   output has_even, output has_odd, output fill_count, input ready);
   modport sink   (input valid, input status, input even_peek, input odd_peek,
                   input has_even, input has_odd, input fill_count, output ready);
endinterface

`default_nettype wire

>>> design/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// sequencer: accept, execute, fetch, respond
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ctrl import psd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_FETCH = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            // wait here while the previous beat is still unclaimed
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> design/psd_dpath.sv
// ----------------------------------------------------------------------------
// psd_dpath
// word store, front/back indices, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module psd_dpath import psd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output stat_type                      stat,
   input  wire logic [OP_W-1:0]          req_operation,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic [STAT_W-1:0]             rsp_status,
   output logic signed [WORD_W-1:0]      rsp_even_peek,
   output logic signed [WORD_W-1:0]      rsp_odd_peek,
   output logic                          rsp_has_even,
   output logic                          rsp_has_odd,
   output logic [FILL_W-1:0]             rsp_fill_count
);

   logic [WORD_W-1:0] mem [DEPTH];

   op_type            op_ff;
   logic [WORD_W-1:0] value_ff;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              front_odd_ff, back_odd_ff;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] rd_front_ff, rd_back_ff;

   logic              we;
   logic [IDX_W-1:0]  waddr;
   logic              empty, full, nonempty;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic signed [WORD_W-1:0] rsp_even_ff, rsp_odd_ff;
   logic                     rsp_has_even_ff, rsp_has_odd_ff;
   logic [FILL_W-1:0]        rsp_fill_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff >= CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      we        = 1'b0;
      waddr     = front_ff;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (empty) begin
               we       = 1'b1;
               waddr    = front_ff;
               back_in  = front_ff;
               count_in = CNT_W'(1);
            end else if (!value_ff[0]) begin
               we       = 1'b1;
               waddr    = idx_dec(front_ff);
               front_in = idx_dec(front_ff);
               count_in = count_ff + CNT_W'(1);
            end else begin
               we       = 1'b1;
               waddr    = idx_inc(back_ff);
               back_in  = idx_inc(back_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DEL_EVEN: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (front_odd_ff) begin
               status_in = ST_NO_EVEN;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  back_in = front_ff;
               end else begin
                  front_in = idx_inc(front_ff);
               end
            end
         end
         OP_DEL_ODD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!back_odd_ff) begin
               status_in = ST_NO_ODD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  front_in = back_ff;
               end else begin
                  back_in = idx_dec(back_ff);
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            front_in = '0;
            back_in  = '0;
         end
         default: status_in = ST_OK;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
      if (cmd.load_rsp) begin
         front_odd_ff <= rd_front_ff[0];
         back_odd_ff  <= rd_back_ff[0];
      end
   end

   // word store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd.exec && we) begin
         mem[waddr] <= value_ff;
      end
      if (cmd.fetch) begin
         rd_front_ff <= mem[front_ff];
         rd_back_ff  <= mem[back_ff];
      end
   end

   // result register
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff   <= status_ff;
         rsp_has_even_ff <= nonempty && !rd_front_ff[0];
         rsp_has_odd_ff  <= nonempty && rd_back_ff[0];
         rsp_even_ff     <= (nonempty && !rd_front_ff[0]) ? rd_front_ff : WORD_W'(1);
         rsp_odd_ff      <= (nonempty && rd_back_ff[0]) ? rd_back_ff : '0;
         rsp_fill_ff     <= FILL_W'(count_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_even_peek  = rsp_even_ff;
   assign rsp_odd_peek   = rsp_odd_ff;
   assign rsp_has_even   = rsp_has_even_ff;
   assign rsp_has_odd    = rsp_has_odd_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

`default_nettype wire

>>> design/parity_split_deque.sv
// ----------------------------------------------------------------------------
// parity_split_deque
// bounded deque of signed words: even words enter at the front, odd at the back
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents
//   req_bus   in    operation (2b), value (32b signed)
//   rsp_bus   out   status, even_peek, odd_peek, has_even, has_odd, fill_count
//
// - one beat at a time in four steps: accept, execute, fetch, respond
// - the fetch cycle is set by the store's two registered read ports (front, back)
// - the output register lets a result wait while the next request is accepted
// - a stalled result holds the sequencer in respond until the output register frees
// - synchronous reset empties the deque at once; no clearing pass over the store
// - unwritten store entries are never shown, as an empty deque masks both peeks
//
`default_nettype none

module parity_split_deque import psd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   psd_req_if.sink   req_bus,
   psd_rsp_if.source rsp_bus
);

   cmd_type  cmd;    // sequencer commands
   stat_type stat;   // datapath status back to the sequencer

   // sequencer: one beat in flight at a time
   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, indices, fill count and the result register
   psd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_bus.operation),
      .req_value      (req_bus.value),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_status     (rsp_bus.status),
      .rsp_even_peek  (rsp_bus.even_peek),
      .rsp_odd_peek   (rsp_bus.odd_peek),
      .rsp_has_even   (rsp_bus.has_even),
      .rsp_has_odd    (rsp_bus.has_odd),
      .rsp_fill_count (rsp_bus.fill_count)
   );

endmodule

`default_nettype wire

>>> design/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// port level checks on result beats of the parity split deque
// ----------------------------------------------------------------------------
`default_nettype none

module psd_checker import psd_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [STAT_W-1:0]        rsp_status,
   input wire logic signed [WORD_W-1:0] rsp_even_peek,
   input wire logic signed [WORD_W-1:0] rsp_odd_peek,
   input wire logic                     rsp_has_even,
   input wire logic                     rsp_has_odd,
   input wire logic [FILL_W-1:0]        rsp_fill_count
);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count <= FILL_W'(DEPTH))
      else $error("fill count beyond depth");

   a_even_peek: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_even ? !rsp_even_peek[0] : (rsp_even_peek == WORD_W'(1))))
      else $error("even peek disagrees with its flag");

   a_odd_peek: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_odd ? rsp_odd_peek[0] : (rsp_odd_peek == '0)))
      else $error("odd peek disagrees with its flag");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill_count == '0) |-> (!rsp_has_even && !rsp_has_odd))
      else $error("flags set on an empty deque");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                     && $stable(rsp_even_peek) && $stable(rsp_odd_peek)
                                     && $stable(rsp_fill_count)))
      else $error("stalled result beat changed");

endmodule

bind parity_split_deque psd_checker u_psd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_even_peek  (rsp_bus.even_peek),
   .rsp_odd_peek   (rsp_bus.odd_peek),
   .rsp_has_even   (rsp_bus.has_even),
   .rsp_has_odd    (rsp_bus.has_odd),
   .rsp_fill_count (rsp_bus.fill_count)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the parity split deque: a queue-fed request
// driver, a result monitor scored against a cycle-free deque predictor,
// three random phases and one long result hold-off
// ----------------------------------------------------------------------------

module tb_top import psd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no beat on either channel before the run is abandoned
   localparam int unsigned STALL_LIMIT = 2000;
   // length of the forced result hold-off
   localparam int unsigned HOLD_CYCLES = 64;
   // random requests per phase
   localparam int unsigned PHASE_BEATS = 375;
   // quiet cycles after the last result before the verdict
   localparam int unsigned TAIL_CYCLES = 20;

   typedef struct {
      op_type                   operation;
      logic signed [WORD_W-1:0] value;
   } deque_cmd_type;

   typedef struct {
      status_type               status;
      logic signed [WORD_W-1:0] even_peek;
      logic signed [WORD_W-1:0] odd_peek;
      logic                     has_even;
      logic                     has_odd;
      logic [FILL_W-1:0]        fill_count;
   } deque_result_type;

   logic clock;
   logic reset;

   psd_req_if req_bus ();
   psd_rsp_if rsp_bus ();

   parity_split_deque DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // request beats waiting to be driven, and results owed by the block
   deque_cmd_type    cmd_queue[$];
   deque_result_type result_queue[$];

   // idling odds in percent, set per phase by the sequencer
   int unsigned req_gap_pct;
   int unsigned rsp_gap_pct;

   // hold-off request: the sequencer bumps the ticket, the monitor serves it
   int unsigned hold_ticket;
   int unsigned hold_seen;
   int unsigned hold_left;

   int unsigned fail_count;
   int unsigned quiet_cycles;

   // predictor state: circular word store with front and back slots
   logic signed [WORD_W-1:0] model_words[DEPTH];
   logic [IDX_W-1:0]         model_front = '0;
   logic [IDX_W-1:0]         model_back  = '0;
   logic [CNT_W-1:0]         model_count = '0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // -------------------------------------------------------------------------
   // predictor: applies one request to the deque copy, returns the result beat
   // -------------------------------------------------------------------------
   function automatic deque_result_type apply_deque_op(input deque_cmd_type cmd);
      deque_result_type         res;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] back_word;
      res.status     = ST_OK;
      res.even_peek  = 1;
      res.odd_peek   = 0;
      res.has_even   = 1'b0;
      res.has_odd    = 1'b0;
      case (cmd.operation)
         OP_INSERT: begin
            if (model_count == CNT_W'(DEPTH)) begin
               res.status = ST_FULL;
            end else if (model_count == '0) begin
               // first word lands on the front slot whatever its parity
               model_words[model_front] = cmd.value;
               model_back  = model_front;
               model_count = CNT_W'(1);
            end else if (!cmd.value[0]) begin
               model_front = (model_front == '0) ? IDX_W'(DEPTH - 1)
                                                 : model_front - IDX_W'(1);
               model_words[model_front] = cmd.value;
               model_count = model_count + CNT_W'(1);
            end else begin
               model_back = (model_back == IDX_W'(DEPTH - 1)) ? '0
                                                              : model_back + IDX_W'(1);
               model_words[model_back] = cmd.value;
               model_count = model_count + CNT_W'(1);
            end
         end
         OP_DEL_EVEN: begin
            if (model_count == '0) begin
               res.status = ST_EMPTY;
            end else if (model_words[model_front][0]) begin
               res.status = ST_NO_EVEN;
            end else begin
               model_count = model_count - CNT_W'(1);
               if (model_count == '0)
                  model_back = model_front;
               else
                  model_front = (model_front == IDX_W'(DEPTH - 1)) ? '0
                                                                   : model_front + IDX_W'(1);
            end
         end
         OP_DEL_ODD: begin
            if (model_count == '0) begin
               res.status = ST_EMPTY;
            end else if (!model_words[model_back][0]) begin
               res.status = ST_NO_ODD;
            end else begin
               model_count = model_count - CNT_W'(1);
               if (model_count == '0)
                  model_front = model_back;
               else
                  model_back = (model_back == '0) ? IDX_W'(DEPTH - 1)
                                                  : model_back - IDX_W'(1);
            end
         end
         default: begin
            model_count = '0;
            model_front = '0;
            model_back  = '0;
         end
      endcase
      // peeks only look at words that have been written
      if (model_count != '0) begin
         front_word = model_words[model_front];
         back_word  = model_words[model_back];
         if (!front_word[0]) begin
            res.has_even  = 1'b1;
            res.even_peek = front_word;
         end
         if (back_word[0]) begin
            res.has_odd  = 1'b1;
            res.odd_peek = back_word;
         end
      end
      res.fill_count = FILL_W'(model_count);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // request driver: new beat only when the bus is free or its beat was taken
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      deque_cmd_type beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            beat.operation = op_type'(req_bus.operation);
            beat.value     = req_bus.value;
            result_queue.push_back(apply_deque_op(beat));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= req_gap_pct) begin
               beat = cmd_queue.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.operation <= beat.operation;
               req_bus.value     <= beat.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // result monitor: scores each accepted beat, then picks the next ready
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      deque_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_seen     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (result_queue.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  fail_count++;
               end
               if (rsp_bus.even_peek !== want.even_peek) begin
                  $error("even_peek: expected %0d, got %0d", want.even_peek,
                         rsp_bus.even_peek);
                  fail_count++;
               end
               if (rsp_bus.odd_peek !== want.odd_peek) begin
                  $error("odd_peek: expected %0d, got %0d", want.odd_peek, rsp_bus.odd_peek);
                  fail_count++;
               end
               if (rsp_bus.has_even !== want.has_even) begin
                  $error("has_even: expected %0d, got %0d", want.has_even, rsp_bus.has_even);
                  fail_count++;
               end
               if (rsp_bus.has_odd !== want.has_odd) begin
                  $error("has_odd: expected %0d, got %0d", want.has_odd, rsp_bus.has_odd);
                  fail_count++;
               end
               if (rsp_bus.fill_count !== want.fill_count) begin
                  $error("fill_count: expected %0d, got %0d", want.fill_count,
                         rsp_bus.fill_count);
                  fail_count++;
               end
            end
         end
         // long hold-off so the block backs up into the request channel
         if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_ticket != hold_seen) begin
            hold_seen     <= hold_ticket;
            hold_left     <= HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_gap_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: no beat on either channel for too long ends the run
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_cmd(input op_type op, input logic signed [WORD_W-1:0] v);
      deque_cmd_type c;
      c.operation = op;
      c.value     = v;
      cmd_queue.push_back(c);
   endtask

   // value mix: extremes, small words around zero and full-width noise
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 0;
               3: return -1;
               4: return 1;
               default: return -2;
            endcase
         end
         1, 2: return $signed(WORD_W'($urandom_range(15))) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   // bursts lean towards filling, draining or neither so that both the full
   // and the empty corners and the wrap of both slots are visited often
   task automatic add_random_burst(input int unsigned beats);
      int unsigned lean;
      int unsigned r;
      for (int unsigned i = 0; i < beats; i++) begin
         if (i % 30 == 0)
            lean = $urandom_range(2);
         r = $urandom_range(99);
         case (lean)
            0: begin
               if (r < 80)      add_cmd(OP_INSERT, pick_word());
               else if (r < 89) add_cmd(OP_DEL_EVEN, pick_word());
               else if (r < 98) add_cmd(OP_DEL_ODD, pick_word());
               else             add_cmd(OP_CLEAR, pick_word());
            end
            1: begin
               if (r < 20)      add_cmd(OP_INSERT, pick_word());
               else if (r < 59) add_cmd(OP_DEL_EVEN, pick_word());
               else if (r < 98) add_cmd(OP_DEL_ODD, pick_word());
               else             add_cmd(OP_CLEAR, pick_word());
            end
            default: begin
               if (r < 50)      add_cmd(OP_INSERT, pick_word());
               else if (r < 74) add_cmd(OP_DEL_EVEN, pick_word());
               else if (r < 98) add_cmd(OP_DEL_ODD, pick_word());
               else             add_cmd(OP_CLEAR, pick_word());
            end
         endcase
      end
   endtask

   // sampled on the falling edge, away from the driving edge
   task automatic wait_drained();
      while (cmd_queue.size() != 0 || req_bus.valid || result_queue.size() != 0)
         @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;
      req_gap_pct       = 8;
      rsp_gap_pct       = 60;
      hold_ticket       = 0;
      fail_count        = 0;
      quiet_cycles      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // deletes on an empty store
      add_cmd(OP_DEL_EVEN, 0);
      add_cmd(OP_DEL_ODD, 32'sh7FFF_FFFF);
      // negative odd word alone: wrong-parity delete refused, then removed
      add_cmd(OP_INSERT, -1);
      add_cmd(OP_DEL_EVEN, 0);
      add_cmd(OP_DEL_ODD, 0);
      // most negative word alone refuses an odd delete and stays
      add_cmd(OP_INSERT, 32'sh8000_0000);
      add_cmd(OP_DEL_ODD, 0);
      // odd at the back, even at the front
      add_cmd(OP_INSERT, 32'sh7FFF_FFFF);
      add_cmd(OP_INSERT, 0);
      add_cmd(OP_DEL_ODD, -1);
      // back word now even with more than one stored
      add_cmd(OP_DEL_ODD, 0);
      add_cmd(OP_DEL_EVEN, 0);
      // fill to the brim, both slots wrapping, then bounce off the full store
      for (int i = 0; i < 15; i++)
         add_cmd(OP_INSERT, (i % 2) ? ($signed($urandom) | 1) : ($signed($urandom) & ~1));
      add_cmd(OP_INSERT, -2);
      add_cmd(OP_CLEAR, 32'sh7FFF_FFFF);

      add_random_burst(PHASE_BEATS);
      wait_drained();

      // sender idles often, receiver rarely
      req_gap_pct = 60;
      rsp_gap_pct = 8;
      add_random_burst(PHASE_BEATS);
      wait_drained();

      // no idling, with one long result hold-off while requests keep coming
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      add_random_burst(PHASE_BEATS);
      hold_ticket = hold_ticket + 1;
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && result_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
